[sv/slstm_pkg.sv]
// Shared types, constants and activation table builders for the scalar LSTM cell.
`default_nettype none
package slstm_pkg;

    localparam int FRAC_BITS       = 12;
    localparam int ACT_TABLE_DEPTH = 256;
    localparam int DATA_W          = 16;
    localparam int PARAM_W         = 48;
    localparam int NUM_GATES       = 4;
    localparam int GATE_W          = 2;
    localparam int CFG_INDEX_W     = 3;
    localparam int SUM_W           = 2 * DATA_W + 2;
    localparam int DATA_MAX        = 2 ** (DATA_W - 1) - 1;
    localparam int DATA_MIN        = -(2 ** (DATA_W - 1));

    localparam logic [GATE_W-1:0] GATE_FORGET = 2'd0;
    localparam logic [GATE_W-1:0] GATE_INPUT  = 2'd1;
    localparam logic [GATE_W-1:0] GATE_CAND   = 2'd2;
    localparam logic [GATE_W-1:0] GATE_OUTPUT = 2'd3;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] hidden_out;
        logic signed [DATA_W-1:0] cell_out;
    } out_item_t;

    typedef enum logic [2:0] {
        MUL_ACC_W,
        MUL_HID_HW,
        MUL_CELL_F,
        MUL_IG_CG,
        MUL_OG_TC
    } mul_sel_t;

    typedef enum logic [1:0] {
        SUM_HOLD,
        SUM_BIAS,
        SUM_ZERO,
        SUM_ADD
    } sum_op_t;

    typedef struct packed {
        mul_sel_t          mul_sel;
        sum_op_t           sum_op;
        logic [GATE_W-1:0] gate;
        logic              pre_en;
        logic              gate_wr;
        logic              cell_wr;
        logic              tc_wr;
        logic              hid_wr;
        logic              charge;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

    // Restoring divide, elaboration time only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^y in Q24 by Taylor series, y in the cell's fixed-point format.
    function automatic logic [63:0] exp_q24(input logic [63:0] y_in, input int frac);
        logic [63:0] y;
        logic [63:0] cap;
        logic [63:0] term;
        logic [63:0] sum;
        logic        done;
        cap  = 64'd16 << frac;
        y    = (y_in > cap) ? cap : y_in;
        term = 64'd1 << 24;
        sum  = term;
        done = 1'b0;
        for (int k = 1; k <= 96; k++) begin
            if (!done) begin
                term = udiv64(term * y, 64'(k) << frac);
                if (term == 64'd0) begin
                    done = 1'b1;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // One activation table entry at the bucket midpoint.
    function automatic logic signed [DATA_W-1:0] act_entry(input int j, input int depth,
                                                           input int frac, input logic use_tanh);
        longint                   m;
        logic [63:0]              a;
        logic [63:0]              e;
        logic [63:0]              num;
        logic [63:0]              q;
        logic signed [DATA_W-1:0] t16;
        m = longint'(udiv64(64'(2 * j + 1) * 64'd32768, 64'(depth))) - 64'sd32768;
        a = (m < 0) ? 64'(-m) : 64'(m);
        if (use_tanh) begin
            e   = exp_q24(a << 1, frac);
            q   = udiv64(((e - 64'd1) << frac) + ((e + 64'd1) >> 1), e + 64'd1);
            t16 = q[DATA_W-1:0];
            return (m < 0) ? -t16 : t16;
        end
        e   = exp_q24(a, frac);
        num = (m >= 0) ? e : (64'd1 << 24);
        q   = udiv64((num << frac) + ((e + 64'd1) >> 1), e + 64'd1);
        return q[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

[sv/slstm_ctrl.sv]
// Sequencer for the LSTM cell: steps the shared multiplier through gates, cell and hidden.
`default_nettype none
module slstm_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_kind,
    output      logic                  s_ready,
    input  wire logic                  m_ready,
    input  wire slstm_pkg::dp_status_t status,
    output      slstm_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_G_A  = 4'd1;
    localparam logic [3:0] ST_G_H  = 4'd2;
    localparam logic [3:0] ST_G_S  = 4'd3;
    localparam logic [3:0] ST_G_R  = 4'd4;
    localparam logic [3:0] ST_G_T  = 4'd5;
    localparam logic [3:0] ST_C_A  = 4'd6;
    localparam logic [3:0] ST_C_B  = 4'd7;
    localparam logic [3:0] ST_C_S  = 4'd8;
    localparam logic [3:0] ST_C_R  = 4'd9;
    localparam logic [3:0] ST_H_T  = 4'd10;
    localparam logic [3:0] ST_H_M  = 4'd11;
    localparam logic [3:0] ST_H_S  = 4'd12;
    localparam logic [3:0] ST_H_R  = 4'd13;
    localparam logic [3:0] ST_FIN  = 4'd14;

    logic [3:0]                       state_reg, state_next;
    logic [slstm_pkg::GATE_W-1:0]     gate_reg, gate_next;

    always_comb begin
        state_next   = state_reg;
        gate_next    = gate_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = slstm_pkg::MUL_ACC_W;
        cmd.sum_op   = slstm_pkg::SUM_HOLD;
        cmd.gate     = gate_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_kind) begin
                        state_next = ST_G_A;
                        gate_next  = slstm_pkg::GATE_FORGET;
                    end else begin
                        cmd.charge = 1'b1;
                    end
                end
            end
            ST_G_A: begin
                cmd.mul_sel = slstm_pkg::MUL_ACC_W;
                cmd.sum_op  = slstm_pkg::SUM_BIAS;
                state_next  = ST_G_H;
            end
            ST_G_H: begin
                cmd.mul_sel = slstm_pkg::MUL_HID_HW;
                cmd.sum_op  = slstm_pkg::SUM_ADD;
                state_next  = ST_G_S;
            end
            ST_G_S: begin
                cmd.sum_op = slstm_pkg::SUM_ADD;
                state_next = ST_G_R;
            end
            ST_G_R: begin
                cmd.pre_en = 1'b1;
                state_next = ST_G_T;
            end
            ST_G_T: begin
                cmd.gate_wr = 1'b1;
                if (gate_reg == slstm_pkg::GATE_OUTPUT) begin
                    state_next = ST_C_A;
                end else begin
                    gate_next  = gate_reg + 1'b1;
                    state_next = ST_G_A;
                end
            end
            ST_C_A: begin
                cmd.mul_sel = slstm_pkg::MUL_CELL_F;
                cmd.sum_op  = slstm_pkg::SUM_ZERO;
                state_next  = ST_C_B;
            end
            ST_C_B: begin
                cmd.mul_sel = slstm_pkg::MUL_IG_CG;
                cmd.sum_op  = slstm_pkg::SUM_ADD;
                state_next  = ST_C_S;
            end
            ST_C_S: begin
                cmd.sum_op = slstm_pkg::SUM_ADD;
                state_next = ST_C_R;
            end
            ST_C_R: begin
                cmd.cell_wr = 1'b1;
                state_next  = ST_H_T;
            end
            ST_H_T: begin
                cmd.tc_wr  = 1'b1;
                state_next = ST_H_M;
            end
            ST_H_M: begin
                cmd.mul_sel = slstm_pkg::MUL_OG_TC;
                cmd.sum_op  = slstm_pkg::SUM_ZERO;
                state_next  = ST_H_S;
            end
            ST_H_S: begin
                cmd.sum_op = slstm_pkg::SUM_ADD;
                state_next = ST_H_R;
            end
            ST_H_R: begin
                cmd.hid_wr = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!status.out_valid || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gate_reg  <= slstm_pkg::GATE_FORGET;
        end else begin
            state_reg <= state_next;
            gate_reg  <= gate_next;
        end
    end

endmodule
`default_nettype wire

[sv/slstm_dp.sv]
// Datapath of the LSTM cell: gate registers, shared multiplier, accumulator, tables, output.
`default_nettype none
module slstm_dp #(
    parameter int FRAC_BITS       = slstm_pkg::FRAC_BITS,
    parameter int ACT_TABLE_DEPTH = slstm_pkg::ACT_TABLE_DEPTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire slstm_pkg::ctrl_cmd_t                cmd,
    output      slstm_pkg::dp_status_t               status,
    input  wire slstm_pkg::in_item_t                 s_data,
    input  wire logic                                m_ready,
    output      logic                                m_valid,
    output      slstm_pkg::out_item_t                m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [slstm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [slstm_pkg::PARAM_W-1:0]       cfg_wdata
);

    localparam int DW     = slstm_pkg::DATA_W;
    localparam int SW     = slstm_pkg::SUM_W;
    localparam int NG     = slstm_pkg::NUM_GATES;
    localparam int IDX_W  = $clog2(ACT_TABLE_DEPTH);
    localparam int PROD_W = DW + IDX_W + 1;

    localparam logic [PROD_W-1:0] DEPTH_K  = PROD_W'(ACT_TABLE_DEPTH);
    localparam logic signed [SW:0] RS_HALF = (SW + 1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SW:0] RS_MAX  = (SW + 1)'(slstm_pkg::DATA_MAX);
    localparam logic signed [SW:0] RS_MIN  = (SW + 1)'(slstm_pkg::DATA_MIN);
    localparam logic signed [DW:0] AC_MAX  = (DW + 1)'(slstm_pkg::DATA_MAX);
    localparam logic signed [DW:0] AC_MIN  = (DW + 1)'(slstm_pkg::DATA_MIN);

    logic [slstm_pkg::PARAM_W-1:0] params_reg [NG];
    logic [slstm_pkg::PARAM_W-1:0] params_next [NG];
    logic signed [DW-1:0]          gv_reg [NG];
    logic signed [DW-1:0]          gv_next [NG];
    logic signed [DW-1:0]          acc_reg, acc_next;
    logic signed [DW-1:0]          cell_reg, cell_next;
    logic signed [DW-1:0]          hid_reg, hid_next;
    logic signed [DW-1:0]          tc_reg, tc_next;
    logic signed [DW-1:0]          pre_reg, pre_next;
    logic signed [2*DW-1:0]        prod_reg, prod_next;
    logic signed [SW-1:0]          sum_reg, sum_next;
    slstm_pkg::out_item_t          out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    logic [slstm_pkg::PARAM_W-1:0] sel_param;
    logic signed [DW-1:0]          w_g, hw_g, bias_g;
    logic signed [DW-1:0]          op_a, op_b;
    logic signed [SW:0]            rnd_full;
    logic signed [DW-1:0]          sat_val;
    logic signed [DW:0]            acc_sum;
    logic signed [DW-1:0]          acc_sat;
    logic signed [DW-1:0]          act_src;
    logic [PROD_W-1:0]             act_prod;
    logic [IDX_W-1:0]              act_idx;
    logic signed [DW-1:0]          sig_val, tanh_val;
    logic signed [DW-1:0]          sig_tab [ACT_TABLE_DEPTH];
    logic signed [DW-1:0]          tanh_tab [ACT_TABLE_DEPTH];

    for (genvar j = 0; j < ACT_TABLE_DEPTH; j++) begin : g_act
        localparam logic signed [DW-1:0] SIG_E  =
            slstm_pkg::act_entry(j, ACT_TABLE_DEPTH, FRAC_BITS, 1'b0);
        localparam logic signed [DW-1:0] TANH_E =
            slstm_pkg::act_entry(j, ACT_TABLE_DEPTH, FRAC_BITS, 1'b1);
        assign sig_tab[j]  = SIG_E;
        assign tanh_tab[j] = TANH_E;
    end

    assign sel_param = params_reg[cmd.gate];
    assign w_g       = sel_param[DW-1:0];
    assign hw_g      = sel_param[2*DW-1:DW];
    assign bias_g    = sel_param[3*DW-1:2*DW];

    always_comb begin
        unique case (cmd.mul_sel)
            slstm_pkg::MUL_ACC_W:  begin op_a = acc_reg;                        op_b = w_g;    end
            slstm_pkg::MUL_HID_HW: begin op_a = hid_reg;                        op_b = hw_g;   end
            slstm_pkg::MUL_CELL_F: begin op_a = cell_reg;  op_b = gv_reg[slstm_pkg::GATE_FORGET]; end
            slstm_pkg::MUL_IG_CG:  begin
                op_a = gv_reg[slstm_pkg::GATE_INPUT];
                op_b = gv_reg[slstm_pkg::GATE_CAND];
            end
            slstm_pkg::MUL_OG_TC:  begin op_a = gv_reg[slstm_pkg::GATE_OUTPUT]; op_b = tc_reg; end
            default:               begin op_a = acc_reg;                        op_b = w_g;    end
        endcase
    end

    assign prod_next = op_a * op_b;

    always_comb begin
        unique case (cmd.sum_op)
            slstm_pkg::SUM_HOLD: sum_next = sum_reg;
            slstm_pkg::SUM_BIAS: sum_next = SW'(bias_g) <<< FRAC_BITS;
            slstm_pkg::SUM_ZERO: sum_next = '0;
            slstm_pkg::SUM_ADD:  sum_next = sum_reg + SW'(prod_reg);
            default:             sum_next = sum_reg;
        endcase
    end

    // Round half up, then clamp to the data range.
    assign rnd_full = ((SW + 1)'(sum_reg) + RS_HALF) >>> FRAC_BITS;

    always_comb begin
        priority if (rnd_full > RS_MAX) begin
            sat_val = DW'(slstm_pkg::DATA_MAX);
        end else if (rnd_full < RS_MIN) begin
            sat_val = DW'(slstm_pkg::DATA_MIN);
        end else begin
            sat_val = rnd_full[DW-1:0];
        end
    end

    assign acc_sum = {acc_reg[DW-1], acc_reg} + {s_data.value[DW-1], s_data.value};

    always_comb begin
        priority if (acc_sum > AC_MAX) begin
            acc_sat = DW'(slstm_pkg::DATA_MAX);
        end else if (acc_sum < AC_MIN) begin
            acc_sat = DW'(slstm_pkg::DATA_MIN);
        end else begin
            acc_sat = acc_sum[DW-1:0];
        end
    end

    assign act_src  = cmd.tc_wr ? cell_reg : pre_reg;
    assign act_prod = PROD_W'({~act_src[DW-1], act_src[DW-2:0]}) * DEPTH_K;
    assign act_idx  = act_prod[DW +: IDX_W];
    assign sig_val  = sig_tab[act_idx];
    assign tanh_val = tanh_tab[act_idx];

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            params_next[g] = params_reg[g];
            gv_next[g]     = gv_reg[g];
            if (cfg_wr_en && cfg_index == slstm_pkg::CFG_INDEX_W'(g)) begin
                params_next[g] = cfg_wdata;
            end
            if (cmd.gate_wr && cmd.gate == slstm_pkg::GATE_W'(g)) begin
                gv_next[g] = (cmd.gate == slstm_pkg::GATE_CAND) ? tanh_val : sig_val;
            end
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.charge) begin
            acc_next = acc_sat;
        end else if (cmd.out_load) begin
            acc_next = '0;
        end
    end

    assign pre_next       = cmd.pre_en  ? sat_val  : pre_reg;
    assign cell_next      = cmd.cell_wr ? sat_val  : cell_reg;
    assign hid_next       = cmd.hid_wr  ? sat_val  : hid_reg;
    assign tc_next        = cmd.tc_wr   ? tanh_val : tc_reg;
    assign out_valid_next = cmd.out_load | (out_valid_reg & ~m_ready);

    always_comb begin
        out_next = out_reg;
        if (cmd.out_load) begin
            out_next.hidden_out = hid_reg;
            out_next.cell_out   = cell_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NG; g++) begin
                params_reg[g] <= '0;
            end
            acc_reg       <= '0;
            cell_reg      <= '0;
            hid_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            for (int g = 0; g < NG; g++) begin
                params_reg[g] <= params_next[g];
            end
            acc_reg       <= acc_next;
            cell_reg      <= cell_next;
            hid_reg       <= hid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            gv_reg[g] <= gv_next[g];
        end
        tc_reg   <= tc_next;
        pre_reg  <= pre_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        out_reg  <= out_next;
    end

    assign status.out_valid = out_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_data           = out_reg;

endmodule
`default_nettype wire

[sv/scalar_lstm_cell_inference.sv]
// Top level of the scalar LSTM cell: sequencer plus datapath.
// Charge transaction: one per cycle while no fire is in progress, no result.
// Fire transaction: no new transaction is taken until the result is loaded into the output slot;
// the single shared 16x16 multiplier steps eleven products through gates, cell and hidden state.
// A pending result does not block charges; a fire finishing early waits for the output slot.
// Reset (aresetn low, synchronous) clears weights, accumulator, cell and hidden state.
`default_nettype none
module scalar_lstm_cell_inference #(
    parameter int FRAC_BITS       = slstm_pkg::FRAC_BITS,
    parameter int ACT_TABLE_DEPTH = slstm_pkg::ACT_TABLE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire slstm_pkg::in_item_t               s_data,
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      slstm_pkg::out_item_t              m_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [slstm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [slstm_pkg::PARAM_W-1:0]     cfg_wdata
);

    slstm_pkg::ctrl_cmd_t  cmd;
    slstm_pkg::dp_status_t status;

    slstm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    slstm_dp #(
        .FRAC_BITS       (FRAC_BITS),
        .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

[sv/slstm_checker.sv]
// Port-level checks for the scalar LSTM cell and their bind to the top level.
`default_nettype none
module slstm_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire slstm_pkg::in_item_t  s_data,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire slstm_pkg::out_item_t m_data
);

    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_fire_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind |=> !s_ready)
        else $error("input still ready after a fire transaction");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a fire in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

endmodule

bind scalar_lstm_cell_inference slstm_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

[dv/scalar_lstm_cell_inference_tb.sv]
// Self-checking testbench for the scalar LSTM cell: directed and random transactions.
module scalar_lstm_cell_inference_tb;
    import slstm_pkg::*;

    typedef longint unsigned u64_t;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 75;

    localparam logic KIND_CHARGE = 1'b0;
    localparam logic KIND_FIRE   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_FORGET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CAND   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST   = 3'd7;

    class cell_scoreboard;
        logic [PARAM_W-1:0]       gate_cfg [NUM_GATES];
        logic signed [DATA_W-1:0] acc_q;
        logic signed [DATA_W-1:0] cell_q;
        logic signed [DATA_W-1:0] hidden_q;
        logic signed [DATA_W-1:0] sig_lut  [ACT_TABLE_DEPTH];
        logic signed [DATA_W-1:0] tanh_lut [ACT_TABLE_DEPTH];
        out_item_t                pending_outputs [$];
        int                       errors;

        function new();
            longint m;
            u64_t   a;
            u64_t   e1;
            u64_t   e2;
            u64_t   t;
            u64_t   s;
            u64_t   num;
            foreach (gate_cfg[g]) gate_cfg[g] = '0;
            acc_q    = '0;
            cell_q   = '0;
            hidden_q = '0;
            errors   = 0;
            for (int j = 0; j < ACT_TABLE_DEPTH; j++) begin
                m   = -32768 + (longint'(2 * j + 1) * 32768) / ACT_TABLE_DEPTH;
                a   = u64_t'((m < 0) ? -m : m);
                e2  = exp_q24(a << 1);
                e1  = exp_q24(a);
                t   = (((e2 - 1) << FRAC_BITS) + (e2 + 1) / 2) / (e2 + 1);
                num = (m >= 0) ? e1 : (u64_t'(1) << 24);
                s   = ((num << FRAC_BITS) + (e1 + 1) / 2) / (e1 + 1);
                tanh_lut[j] = (m < 0) ? -DATA_W'(t) : DATA_W'(t);
                sig_lut[j]  = DATA_W'(s);
            end
        endfunction

        // e^y in Q24, y in the cell format, capped at 16.0
        function u64_t exp_q24(u64_t y);
            u64_t cap;
            u64_t term;
            u64_t total;
            cap   = u64_t'(16) << FRAC_BITS;
            term  = u64_t'(1) << 24;
            total = term;
            if (y > cap) y = cap;
            for (int k = 1; k <= 96; k++) begin
                term = (term * y) / (u64_t'(k) << FRAC_BITS);
                if (term == 0) break;
                total += term;
            end
            return total;
        endfunction

        function logic signed [DATA_W-1:0] clamp16(longint v);
            if (v > DATA_MAX) return DATA_W'(DATA_MAX);
            if (v < DATA_MIN) return DATA_W'(DATA_MIN);
            return DATA_W'(v);
        endfunction

        function longint round_q(longint v);
            return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
        endfunction

        function int lut_index(logic signed [DATA_W-1:0] x);
            int idx;
            idx = ((int'(x) + 32768) * ACT_TABLE_DEPTH) >>> 16;
            return (idx < ACT_TABLE_DEPTH) ? idx : ACT_TABLE_DEPTH - 1;
        endfunction

        function logic signed [DATA_W-1:0] gate_pre(logic [GATE_W-1:0] g);
            logic [PARAM_W-1:0] r;
            longint             w;
            longint             hw;
            longint             b;
            r  = gate_cfg[g];
            w  = longint'($signed(r[DATA_W-1:0]));
            hw = longint'($signed(r[2*DATA_W-1:DATA_W]));
            b  = longint'($signed(r[3*DATA_W-1:2*DATA_W]));
            return clamp16(round_q(longint'(acc_q) * w + longint'(hidden_q) * hw
                                   + (b <<< FRAC_BITS)));
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [PARAM_W-1:0] data);
            if (idx < REG_COUNT) gate_cfg[idx[GATE_W-1:0]] = data;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function void take_input(in_item_t it);
            logic signed [DATA_W-1:0] fg;
            logic signed [DATA_W-1:0] ig;
            logic signed [DATA_W-1:0] cg;
            logic signed [DATA_W-1:0] og;
            out_item_t                want;
            if (it.kind == KIND_CHARGE) begin
                acc_q = clamp16(longint'(acc_q) + longint'(it.value));
                return;
            end
            fg = sig_lut[lut_index(gate_pre(GATE_FORGET))];
            ig = sig_lut[lut_index(gate_pre(GATE_INPUT))];
            cg = tanh_lut[lut_index(gate_pre(GATE_CAND))];
            og = sig_lut[lut_index(gate_pre(GATE_OUTPUT))];
            cell_q   = clamp16(round_q(longint'(cell_q) * longint'(fg)
                                       + longint'(ig) * longint'(cg)));
            hidden_q = clamp16(round_q(longint'(og) * longint'(tanh_lut[lut_index(cell_q)])));
            acc_q    = '0;
            want.hidden_out = hidden_q;
            want.cell_out   = cell_q;
            pending_outputs = {pending_outputs, want};
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_output(out_item_t got);
            out_item_t want;
            if (pending_outputs.size() == 0) begin
                report("result transaction with no fire outstanding");
                return;
            end
            want = pending_outputs.pop_front();
            if (got.hidden_out !== want.hidden_out)
                report($sformatf("hidden_out %0d, expected %0d", got.hidden_out, want.hidden_out));
            if (got.cell_out !== want.cell_out)
                report($sformatf("cell_out %0d, expected %0d", got.cell_out, want.cell_out));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_data;
    logic                     m_valid;
    logic                     m_ready;
    out_item_t                m_data;
    logic                     cfg_wr_en;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [PARAM_W-1:0]       cfg_wdata;
    bit                       calm;
    cell_scoreboard           cell_sb;

    scalar_lstm_cell_inference u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // results are checked before the input of the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) cell_sb.check_output(m_data);
            if (s_valid && s_ready) cell_sb.take_input(s_data);
        end
    end

    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_item(input logic kind, input logic signed [DATA_W-1:0] value);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data.kind  <= kind;
        s_data.value <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic wait_idle(input int extra);
        s_valid <= 1'b0;
        do @(negedge aclk); while (cell_sb.pending() != 0);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PARAM_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        cell_sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic apply_config(input logic [PARAM_W-1:0] f_p, input logic [PARAM_W-1:0] i_p,
                                input logic [PARAM_W-1:0] c_p, input logic [PARAM_W-1:0] o_p);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_FORGET, f_p);
        write_reg(REG_INPUT, i_p);
        write_reg(REG_CAND, c_p);
        write_reg(REG_OUTPUT, o_p);
        // unmapped index, must not disturb the gates
        write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, REG_LAST)),
                  PARAM_W'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_field(input bit mild);
        return mild ? DATA_W'($urandom_range(0, 16383)) - 16'd8192 : DATA_W'($urandom);
    endfunction

    function automatic logic [PARAM_W-1:0] rand_params();
        bit mild;
        mild = ($urandom_range(0, 3) != 0);
        return {rand_field(mild), rand_field(mild), rand_field(mild)};
    endfunction

    function automatic logic signed [DATA_W-1:0] charge_value();
        if ($urandom_range(0, 3) == 0) return DATA_W'($urandom);
        return DATA_W'($urandom_range(0, 8191)) - 16'd4096;
    endfunction

    task automatic run_random(input int n);
        int sent;
        int n_charge;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 24) == 0) wait_idle(0);
            if ($urandom_range(0, 9) < 8) begin
                n_charge = $urandom_range(0, 4);
                repeat (n_charge) send_item(KIND_CHARGE, charge_value());
                send_item(KIND_FIRE, DATA_W'($urandom));
                sent += n_charge + 1;
            end else begin
                send_item(1'($urandom), DATA_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        calm      = 1'b0;
        cell_sb   = new();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fire on reset weights, value must be ignored
        send_item(KIND_FIRE, 16'sh7FFF);

        apply_config(48'h0800_0400_1000, 48'h0000_0C00_F000,
                     48'hFC00_1000_2000, 48'h0400_F800_1800);
        send_item(KIND_CHARGE, 16'sh7FFF);
        send_item(KIND_CHARGE, 16'sh7FFF);
        send_item(KIND_FIRE, 16'sh8000);
        send_item(KIND_CHARGE, 16'sh8000);
        send_item(KIND_CHARGE, 16'sh8000);
        send_item(KIND_FIRE, 16'sh0000);
        send_item(KIND_CHARGE, 16'sh0001);
        send_item(KIND_CHARGE, 16'shFFFF);
        send_item(KIND_FIRE, 16'shFFFF);
        send_item(KIND_CHARGE, 16'sh1234);
        send_item(KIND_FIRE, 16'sh5555);
        send_item(KIND_FIRE, 16'shAAAA);
        send_item(KIND_CHARGE, 16'sh0800);
        send_item(KIND_CHARGE, 16'sh0800);
        send_item(KIND_FIRE, 16'sh0000);
        send_item(KIND_CHARGE, 16'shF000);
        send_item(KIND_FIRE, 16'sh0000);
        send_item(KIND_FIRE, 16'sh0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase % 4 == 3);
            case (phase)
                0: apply_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
                1: apply_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
                2: apply_config('1, '1, '1, '1);
                3: apply_config('0, '0, '0, '0);
                default: apply_config(rand_params(), rand_params(), rand_params(), rand_params());
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        wait_idle(SETTLE_CYCLES);
        if (cell_sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
